@@ sv/ewrt_pkg.sv @@
// Shared constants and types for the exponential-with-tails datapath.
package ewrt_pkg;

	localparam int FRAC_BITS = 24;
	localparam int X_W = 32;
	localparam int BOUND_W = 29;
	localparam int RES_W = 64;
	localparam logic [BOUND_W-1:0] BOUND_CAP = BOUND_W'(20 << FRAC_BITS);
	localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_CAP;

	// ln 2 in Q.58 and Q.62
	localparam logic [63:0] LN2_Q58 = 64'h02C5C85FDF473DE7;
	localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;
	localparam int A_SHIFT = 58 - FRAC_BITS;

	// range reduction: k < 32, one quotient bit per stage
	localparam int K_BITS = 5;
	localparam int SH_W = 6;

	// series terms; each term divide runs digit by digit
	localparam int TERMS = 24;
	localparam int DIGIT_W = 16;
	localparam int DIGITS = 4;
	localparam int REM_W = 5;
	localparam int DIG_N_W = REM_W + DIGIT_W;
	localparam int RECIP_SH = DIG_N_W + REM_W;
	localparam int RECIP_W = RECIP_SH + 1;
	localparam int TERM_STAGES = DIGITS + 2;
	localparam int CORE_LAT = K_BITS + 1 + TERMS * TERM_STAGES + 2;

	// tail quotient divider
	localparam int Q_W = 32;
	localparam int DEN_W = 33;
	localparam int DIV_LAT = Q_W + 1;
	localparam int Q_DLY = CORE_LAT - DIV_LAT;

	// start to done, in clock edges
	localparam int LATENCY = 2 + CORE_LAT + 3;

	typedef enum logic [1:0] {
		REG_INSIDE = 2'd0,
		REG_UPPER  = 2'd1,
		REG_LOWER  = 2'd2
	} region_t;

	typedef struct packed {
		logic [BOUND_W-1:0] mag;
		logic               neg;
	} core_req_t;

endpackage

@@ sv/exp_with_rational_tails.sv @@
// Top level: region select, tail quotient divider, exp core and tail blend.
//
//  channel  | signals                           | handshake
//  ---------+-----------------------------------+------------------------------
//  request  | start, busy, x_value              | taken when start & !busy
//  config   | cfg_valid, cfg_ready, domain_bound| written when valid & ready
//  result   | done, exp_result, region          | one-cycle strobe, no backpressure
//
// One request per cycle; each result returns in request order.
// The depth is set by the 24-term series, six stages per term (product,
// round, four 16-bit digits of the divide by the term index).
// busy is always low and cfg_ready always high; nothing ever stalls.
// Reset clears the valid bits and loads the bound with 20.0.
module exp_with_rational_tails import ewrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [X_W-1:0] x_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [BOUND_W-1:0]    domain_bound,
	output logic                  done,
	output logic [RES_W-1:0]      exp_result,
	output logic [1:0]            region
);

	localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;

	logic [BOUND_W-1:0]    bound_q;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [X_W-1:0] x_s1;
	logic [BOUND_W-1:0]    b_s1;

	logic signed [X_W:0]   xw, bw, nbw, d_up, d_lo, ax;
	logic                  upper, lower;

	region_t               reg_s2;
	core_req_t             req_s2;
	logic [X_W-1:0]        d_s2;

	logic [DEN_W-1:0]      dv_rem_s [DIV_LAT];
	logic [DEN_W-1:0]      dv_den_s [DIV_LAT];
	logic [Q_W-1:0]        dv_quo_s [DIV_LAT];
	logic [Q_W-1:0]        q_dly_s [Q_DLY];
	region_t               reg_dly_s [CORE_LAT];

	logic                  core_vld;
	logic [RES_W-1:0]      core_exp;

	logic [RES_W-1:0]      e_s3, e_s4;
	logic [63:0]           pl_s3, ph_s3;
	region_t               reg_s3, reg_s4, reg_s5;
	logic [95:0]           tail_sum;
	logic [RES_W-1:0]      m_s4, res_s5;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= BOUND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bound_q <= domain_bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= core_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: capture, saturate bound
	always_ff @(posedge clk) begin
		x_s1 <= x_value;
		b_s1 <= (bound_q > BOUND_CAP) ? BOUND_CAP : bound_q;
	end

	// stage 2: region and distance beyond the bound
	assign xw    = (X_W+1)'(x_s1);
	assign bw    = $signed({4'b0000, b_s1});
	assign nbw   = -bw;
	assign upper = xw > bw;
	assign lower = xw < nbw;
	assign d_up  = xw - bw;
	assign d_lo  = nbw - xw;
	assign ax    = x_s1[X_W-1] ? -xw : xw;

	always_ff @(posedge clk) begin
		if (upper) begin
			reg_s2     <= REG_UPPER;
			req_s2.mag <= b_s1;
			req_s2.neg <= 1'b0;
			d_s2       <= d_up[X_W-1:0];
		end else if (lower) begin
			reg_s2     <= REG_LOWER;
			req_s2.mag <= b_s1;
			req_s2.neg <= 1'b1;
			d_s2       <= d_lo[X_W-1:0];
		end else begin
			reg_s2     <= REG_INSIDE;
			req_s2.mag <= ax[BOUND_W-1:0];
			req_s2.neg <= x_s1[X_W-1];
			d_s2       <= d_lo[X_W-1:0];
		end
	end

	ewrt_exp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_req    (req_s2),
		.out_valid (core_vld),
		.out_exp   (core_exp)
	);

	// q = floor(d * 2^32 / den), restoring, one quotient bit per stage
	always_ff @(posedge clk) begin
		dv_rem_s[0] <= {1'b0, d_s2};
		dv_den_s[0] <= (reg_s2 == REG_LOWER) ? ONE + {d_s2, 1'b0} : ONE + {1'b0, d_s2};
		dv_quo_s[0] <= '0;
	end

	for (genvar j = 1; j < DIV_LAT; j++) begin : g_div
		logic [DEN_W:0] r2;
		assign r2 = {dv_rem_s[j-1], 1'b0};
		always_ff @(posedge clk) begin
			if (r2 >= {1'b0, dv_den_s[j-1]}) begin
				dv_rem_s[j] <= DEN_W'(r2 - {1'b0, dv_den_s[j-1]});
				dv_quo_s[j] <= {dv_quo_s[j-1][Q_W-2:0], 1'b1};
			end else begin
				dv_rem_s[j] <= r2[DEN_W-1:0];
				dv_quo_s[j] <= {dv_quo_s[j-1][Q_W-2:0], 1'b0};
			end
			dv_den_s[j] <= dv_den_s[j-1];
		end
	end

	// align quotient and region with the core output
	always_ff @(posedge clk) begin
		q_dly_s[0]   <= dv_quo_s[DIV_LAT-1];
		reg_dly_s[0] <= reg_s2;
		for (int i = 1; i < Q_DLY; i++) begin
			q_dly_s[i] <= q_dly_s[i-1];
		end
		for (int i = 1; i < CORE_LAT; i++) begin
			reg_dly_s[i] <= reg_dly_s[i-1];
		end
	end

	// tail: E +/- round(E * q / 2^32)
	always_ff @(posedge clk) begin
		e_s3   <= core_exp;
		pl_s3  <= 64'(core_exp[31:0]) * 64'(q_dly_s[Q_DLY-1]);
		ph_s3  <= 64'(core_exp[63:32]) * 64'(q_dly_s[Q_DLY-1]);
		reg_s3 <= reg_dly_s[CORE_LAT-1];
	end

	assign tail_sum = {ph_s3, 32'd0} + {32'd0, pl_s3} + (96'd1 << 31);

	always_ff @(posedge clk) begin
		e_s4   <= e_s3;
		m_s4   <= tail_sum[95:32];
		reg_s4 <= reg_s3;
	end

	always_ff @(posedge clk) begin
		case (reg_s4)
			REG_UPPER: res_s5 <= e_s4 + m_s4;
			REG_LOWER: res_s5 <= e_s4 - m_s4;
			default:   res_s5 <= e_s4;
		endcase
		reg_s5 <= reg_s4;
	end

	assign done       = vld_s5;
	assign exp_result = res_s5;
	assign region     = reg_s5;

endmodule

@@ sv/ewrt_exp_core.sv @@
// Pipelined e^a / e^-a core: range reduction, 24-term series, final scaling.
module ewrt_exp_core import ewrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  core_req_t        in_req,
	output logic             out_valid,
	output logic [RES_W-1:0] out_exp
);

	typedef struct packed {
		logic [63:0]     term;
		logic [63:0]     sum;
		logic [61:0]     u;
		logic [SH_W-1:0] sh;
	} ser_t;

	typedef struct packed {
		logic [63:0]     p00;
		logic [63:0]     p01;
		logic [63:0]     p10;
		logic [63:0]     p11;
		logic [63:0]     sum;
		logic [61:0]     u;
		logic [SH_W-1:0] sh;
	} mul_t;

	typedef struct packed {
		logic [63:0]      rest;
		logic [63:0]      quo;
		logic [REM_W-1:0] rem;
		logic [63:0]      sum;
		logic [61:0]      u;
		logic [SH_W-1:0]  sh;
	} dig_t;

	logic [CORE_LAT-1:0] vld_q;

	logic [63:0]        a58;
	logic [63:0]        rr_rem_s [K_BITS];
	logic [K_BITS-1:0]  rr_k_s [K_BITS];
	logic               rr_neg_s [K_BITS];

	logic [61:0]        r62;
	ser_t               ser0_s;
	mul_t               mul_s [TERMS];
	dig_t               rnd_s [TERMS];
	dig_t               dig_s [TERMS][DIGITS];
	ser_t               trm [TERMS];

	logic [63:0]        e62_s1;
	logic [SH_W-1:0]    sh_s1;
	logic [RES_W-1:0]   res_s2;
	logic [63:0]        half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[CORE_LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[CORE_LAT-1];

	// k = floor(a / ln2), one bit per stage, MSB first
	assign a58 = 64'(in_req.mag) << A_SHIFT;

	for (genvar j = 0; j < K_BITS; j++) begin : g_rr
		localparam logic [63:0] Step = LN2_Q58 << (K_BITS - 1 - j);
		localparam logic [K_BITS-1:0] Kbit = K_BITS'(1) << (K_BITS - 1 - j);
		logic [63:0]       rem_i;
		logic [K_BITS-1:0] k_i;
		logic              neg_i;
		if (j == 0) begin : g_first
			assign rem_i = a58;
			assign k_i   = '0;
			assign neg_i = in_req.neg;
		end else begin : g_next
			assign rem_i = rr_rem_s[j-1];
			assign k_i   = rr_k_s[j-1];
			assign neg_i = rr_neg_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (rem_i >= Step) begin
				rr_rem_s[j] <= rem_i - Step;
				rr_k_s[j]   <= k_i | Kbit;
			end else begin
				rr_rem_s[j] <= rem_i;
				rr_k_s[j]   <= k_i;
			end
			rr_neg_s[j] <= neg_i;
		end
	end

	// series argument and output shift
	assign r62 = {rr_rem_s[K_BITS-1][57:0], 4'b0000};

	always_ff @(posedge clk) begin
		ser0_s.term <= 64'd1 << 62;
		ser0_s.sum  <= '0;
		if (rr_neg_s[K_BITS-1]) begin
			ser0_s.u  <= LN2_Q62[61:0] - r62;
			ser0_s.sh <= SH_W'(31) + SH_W'(rr_k_s[K_BITS-1]);
		end else begin
			ser0_s.u  <= r62;
			ser0_s.sh <= SH_W'(30) - SH_W'(rr_k_s[K_BITS-1]);
		end
	end

	// term_i = floor(round(term_(i-1) * u / 2^62) / i)
	for (genvar gi = 0; gi < TERMS; gi++) begin : g_term
		localparam int Div = gi + 1;
		localparam logic [RECIP_W-1:0] Recip =
			RECIP_W'(((1 << RECIP_SH) + Div - 1) / Div);
		ser_t         cur;
		logic [64:0]  mid;
		logic [127:0] full;

		if (gi == 0) begin : g_head
			assign cur = ser0_s;
		end else begin : g_chain
			assign cur = trm[gi-1];
		end

		always_ff @(posedge clk) begin
			mul_s[gi].p00 <= 64'(cur.term[31:0]) * 64'(cur.u[31:0]);
			mul_s[gi].p01 <= 64'(cur.term[31:0]) * 64'(cur.u[61:32]);
			mul_s[gi].p10 <= 64'(cur.term[63:32]) * 64'(cur.u[31:0]);
			mul_s[gi].p11 <= 64'(cur.term[63:32]) * 64'(cur.u[61:32]);
			mul_s[gi].sum <= cur.sum + cur.term;
			mul_s[gi].u   <= cur.u;
			mul_s[gi].sh  <= cur.sh;
		end

		assign mid  = {1'b0, mul_s[gi].p01} + {1'b0, mul_s[gi].p10};
		assign full = {mul_s[gi].p11, 64'd0} + {31'd0, mid, 32'd0}
			+ {64'd0, mul_s[gi].p00} + (128'd1 << 61);

		always_ff @(posedge clk) begin
			rnd_s[gi].rest <= full[125:62];
			rnd_s[gi].quo  <= '0;
			rnd_s[gi].rem  <= '0;
			rnd_s[gi].sum  <= mul_s[gi].sum;
			rnd_s[gi].u    <= mul_s[gi].u;
			rnd_s[gi].sh   <= mul_s[gi].sh;
		end

		// long division by a small constant, 16 bits per stage
		for (genvar j = 0; j < DIGITS; j++) begin : g_dig
			dig_t                        din;
			logic [DIG_N_W-1:0]          n;
			logic [DIG_N_W+RECIP_W-1:0]  prod;
			logic [DIGIT_W-1:0]          qd;
			logic [DIG_N_W-1:0]          back;
			if (j == 0) begin : g_d0
				assign din = rnd_s[gi];
			end else begin : g_dn
				assign din = dig_s[gi][j-1];
			end
			assign n    = {din.rem, din.rest[63 -: DIGIT_W]};
			assign prod = (DIG_N_W+RECIP_W)'(n) * (DIG_N_W+RECIP_W)'(Recip);
			assign qd   = prod[RECIP_SH +: DIGIT_W];
			assign back = n - DIG_N_W'(qd) * DIG_N_W'(Div);
			always_ff @(posedge clk) begin
				dig_s[gi][j].rest <= din.rest << DIGIT_W;
				dig_s[gi][j].quo  <= {din.quo[63-DIGIT_W:0], qd};
				dig_s[gi][j].rem  <= back[REM_W-1:0];
				dig_s[gi][j].sum  <= din.sum;
				dig_s[gi][j].u    <= din.u;
				dig_s[gi][j].sh   <= din.sh;
			end
		end

		assign trm[gi].term = dig_s[gi][DIGITS-1].quo;
		assign trm[gi].sum  = dig_s[gi][DIGITS-1].sum;
		assign trm[gi].u    = dig_s[gi][DIGITS-1].u;
		assign trm[gi].sh   = dig_s[gi][DIGITS-1].sh;
	end

	always_ff @(posedge clk) begin
		e62_s1 <= trm[TERMS-1].sum + trm[TERMS-1].term;
		sh_s1  <= trm[TERMS-1].sh;
	end

	// round half up while scaling to Q32.32
	assign half = 64'd1 << (sh_s1 - SH_W'(1));

	always_ff @(posedge clk) begin
		res_s2 <= (e62_s1 + half) >> sh_s1;
	end

	assign out_exp = res_s2;

endmodule

@@ sv/ewrt_chk.sv @@
// Port-level checker for the exponential block, bound to the top level.
module ewrt_chk import ewrt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [RES_W-1:0]      exp_result,
	input logic [1:0]            region
);

	// every request comes back after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request without result");

	// no result without a request
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without request");

	// upper tail is at least e^b >= 1.0
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		done && region == REG_UPPER |-> exp_result >= 64'h0000_0001_0000_0000)
		else $error("upper tail below one");

	// lower tail is at most e^-b <= 1.0
	a_lower: assert property (@(posedge clk) disable iff (!arst_n)
		done && region == REG_LOWER |-> exp_result <= 64'h0000_0001_0000_0000)
		else $error("lower tail above one");

endmodule

bind exp_with_rational_tails ewrt_chk u_ewrt_chk (.*);

@@ dv/tb_exp_with_rational_tails.sv @@
// Self-checking testbench for exp_with_rational_tails.
`timescale 1ns / 1ps

module tb_exp_with_rational_tails;
	import ewrt_pkg::*;

	typedef struct {
		logic [RES_W-1:0] value;
		region_t          reg_id;
	} exp_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic signed [X_W-1:0] x_value;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [BOUND_W-1:0]    domain_bound;
	logic                  done;
	logic [RES_W-1:0]      exp_result;
	logic [1:0]            region;

	logic [X_W-1:0] x_pending[$];
	exp_out_t       exp_expected[$];
	logic [BOUND_W-1:0] bound_copy;
	bit             failed;
	bit             calm;
	int             gap_left;

	exp_with_rational_tails dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .x_value(x_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .domain_bound(domain_bound),
		.done(done), .exp_result(exp_result), .region(region)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// round(a*b / 2^s)
	function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (s - 1));
		return 64'(p >> s);
	endfunction

	function automatic logic [63:0] taylor_q62(logic [63:0] u);
		logic [63:0] sum, term;
		sum = 64'd1 << 62;
		term = sum;
		for (int i = 1; i <= 24; i++) begin
			term = mul_round(term, u, 62) / 64'(i);
			sum = sum + term;
		end
		return sum;
	endfunction

	function automatic logic [63:0] exp_q32(logic [63:0] a, bit neg);
		logic [63:0] a58, k, r62, e62;
		int sh;
		a58 = a << (58 - FRAC_BITS);
		k = a58 / LN2_Q58;
		r62 = (a58 - k * LN2_Q58) << 4;
		if (!neg) begin
			e62 = taylor_q62(r62);
			sh = 30 - int'(k);
		end else begin
			e62 = taylor_q62(LN2_Q62 - r62);
			sh = 31 + int'(k);
		end
		return (e62 + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic exp_out_t predict_exp(logic [X_W-1:0] raw, logic [BOUND_W-1:0] bnd);
		exp_out_t o;
		longint x, b;
		logic [63:0] d, e, q, one;
		x = longint'($signed(raw));
		b = longint'({35'd0, bnd});
		one = 64'd1 << FRAC_BITS;
		if (b > longint'({35'd0, BOUND_CAP}))
			b = longint'({35'd0, BOUND_CAP});
		if (x <= b && x >= -b) begin
			o.value = (x >= 0) ? exp_q32(64'(x), 1'b0) : exp_q32(64'(-x), 1'b1);
			o.reg_id = REG_INSIDE;
		end else if (x > b) begin
			d = 64'(x - b);
			e = exp_q32(64'(b), 1'b0);
			q = (d << 32) / (one + d);
			o.value = e + mul_round(e, q, 32);
			o.reg_id = REG_UPPER;
		end else begin
			d = 64'(-x - b);
			e = exp_q32(64'(b), 1'b1);
			q = (d << 32) / (one + 2 * d);
			o.value = e - mul_round(e, q, 32);
			o.reg_id = REG_LOWER;
		end
		return o;
	endfunction

	// driver: record accepted request, then present the next one or idle
	always @(posedge clk) begin
		logic nxt_start;
		logic [X_W-1:0] nxt_x;
		nxt_start = start;
		nxt_x = x_value;
		if (arst_n) begin
			if (start && !busy) begin
				exp_expected.push_back(predict_exp(x_value, bound_copy));
				nxt_start = 1'b0;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (x_pending.size() > 0) begin
					if (!calm && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(0, 2);
					end else begin
						nxt_start = 1'b1;
						nxt_x = x_pending.pop_front();
					end
				end
			end
		end
		start <= nxt_start;
		x_value <= nxt_x;
	end

	// monitor
	always @(posedge clk) begin
		exp_out_t want;
		if (arst_n && done) begin
			if (exp_expected.size() == 0) begin
				$error("unexpected result: exp_result=%h region=%0d", exp_result, region);
				failed = 1'b1;
			end else begin
				want = exp_expected.pop_front();
				if (exp_result !== want.value) begin
					$error("exp_result: expected %h, got %h", want.value, exp_result);
					failed = 1'b1;
				end
				if (region !== want.reg_id) begin
					$error("region: expected %0d, got %0d", want.reg_id, region);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic drain();
		while (x_pending.size() > 0 || start || exp_expected.size() > 0)
			@(posedge clk);
	endtask

	task automatic set_bound(logic [BOUND_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		domain_bound <= v;
		do @(posedge clk); while (!cfg_ready);
		bound_copy = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic load_requests(int n);
		longint b;
		logic [X_W-1:0] v;
		b = longint'({35'd0, bound_copy});
		if (b > longint'({35'd0, BOUND_CAP}))
			b = longint'({35'd0, BOUND_CAP});
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: v = $urandom();
				1: v = X_W'(b + longint'($signed(X_W'($urandom_range(0, 64)))) - 32);
				2: v = X_W'(-b + longint'($urandom_range(0, 64)) - 32);
				default: v = X_W'(longint'($urandom_range(0, 2 * 20 * (1 << FRAC_BITS)))
					- 20 * (1 << FRAC_BITS));
			endcase
			x_pending.push_back(v);
		end
	endtask

	initial begin
		logic [BOUND_W-1:0] bounds[6];
		arst_n = 1'b0;
		start = 1'b0;
		x_value = '0;
		cfg_valid = 1'b0;
		domain_bound = '0;
		failed = 1'b0;
		calm = 1'b0;
		gap_left = 0;
		bound_copy = BOUND_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset bound
		foreach (bounds[i]) bounds[i] = '0;
		x_pending = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFFFFFF, 32'h80000000,
			32'(20 << FRAC_BITS), -32'(20 << FRAC_BITS), 32'((20 << FRAC_BITS) + 1),
			-32'((20 << FRAC_BITS) + 1), 32'(1 << FRAC_BITS), -32'(1 << FRAC_BITS),
			32'hB17217, -32'hB17217, 32'hFFFFFF, 32'h55555555, 32'hAAAAAAAA};
		drain();

		// zero bound: every nonzero x is in a tail
		set_bound('0);
		x_pending = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFFFFFF, 32'h80000000};
		// oversized bound acts as 20.0
		set_bound('1);
		x_pending = '{32'((20 << FRAC_BITS) + 1), -32'((20 << FRAC_BITS) + 1),
			32'(20 << FRAC_BITS)};

		bounds = '{BOUND_CAP, 29'd1, 29'(3 << FRAC_BITS),
			29'($urandom_range(0, 20 << FRAC_BITS)), '1, '0};
		foreach (bounds[i]) begin
			set_bound(bounds[i]);
			if (i == 5) calm = 1'b1;
			load_requests(100);
		end
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (!failed && exp_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
